// ===== rtl/cmdu_pkg.sv =====
`default_nettype none
package cmdu_pkg;

    localparam int WORD_W = 32;
    localparam int XLEN   = 64;
    localparam int CNT_W  = $clog2(WORD_W);

    typedef enum logic [1:0] {
        MODE_MUL_S = 2'd0,
        MODE_MUL_U = 2'd1,
        MODE_DIV_S = 2'd2,
        MODE_DIV_U = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_FIX,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic mul;
        logic div_step;
        logic fix;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic in_is_mul;
        logic in_dbz;
        logic cnt_last;
    } t_status;

    function automatic logic [XLEN-1:0] sext_word(input logic [WORD_W-1:0] w);
        return {{(XLEN-WORD_W){w[WORD_W-1]}}, w};
    endfunction

endpackage
`default_nettype wire

// ===== rtl/cmdu_ctrl.sv =====
`default_nettype none
module cmdu_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_valid,
    output logic                   o_s_ready,
    output logic                   o_m_valid,
    input  wire logic              i_m_ready,
    input  wire cmdu_pkg::t_status i_status,
    output cmdu_pkg::t_cmd         o_cmd
);

    cmdu_pkg::t_state r_state, n_state;
    logic             r_out_valid;
    logic             accept;

    assign o_s_ready = (r_state == cmdu_pkg::ST_IDLE);
    assign accept    = i_s_valid && o_s_ready;
    assign o_m_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cmdu_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            cmdu_pkg::ST_IDLE: begin
                if (accept) begin
                    o_cmd.load = 1'b1;
                    priority if (i_status.in_is_mul) begin
                        n_state = cmdu_pkg::ST_MUL;
                    end else if (i_status.in_dbz) begin
                        n_state = cmdu_pkg::ST_OUT;
                    end else begin
                        n_state = cmdu_pkg::ST_DIV;
                    end
                end
            end
            cmdu_pkg::ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = cmdu_pkg::ST_OUT;
            end
            cmdu_pkg::ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.cnt_last) begin
                    n_state = cmdu_pkg::ST_FIX;
                end
            end
            cmdu_pkg::ST_FIX: begin
                o_cmd.fix = 1'b1;
                n_state   = cmdu_pkg::ST_OUT;
            end
            cmdu_pkg::ST_OUT: begin
                if (!r_out_valid || i_m_ready) begin
                    o_cmd.commit = 1'b1;
                    n_state      = cmdu_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = cmdu_pkg::ST_IDLE;
            end
        endcase
    end

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_s_ready)
        else $error("new item taken while busy");

    a_div_to_fix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cmdu_pkg::ST_DIV) && i_status.cnt_last |=> (r_state == cmdu_pkg::ST_FIX))
        else $error("divider did not finish after last step");

    a_commit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> o_m_valid)
        else $error("commit without output transfer pending");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_valid && !i_m_ready |=> o_m_valid && !$past(o_cmd.commit))
        else $error("pending result overwritten");

endmodule
`default_nettype wire

// ===== rtl/cmdu_dpath.sv =====
`default_nettype none
module cmdu_dpath (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [71:0]                   i_s_tdata,
    input  wire logic [1:0]                    i_s_tuser,
    input  wire cmdu_pkg::t_cmd                i_cmd,
    output cmdu_pkg::t_status                  o_status,
    output logic [cmdu_pkg::XLEN-1:0]          o_lo,
    output logic [cmdu_pkg::XLEN-1:0]          o_hi,
    output logic [cmdu_pkg::XLEN-1:0]          o_rd_value,
    output logic                               o_rd_write,
    output logic                               o_dbz
);

    localparam int W = cmdu_pkg::WORD_W;

    cmdu_pkg::t_mode in_mode;
    logic [W-1:0]    in_a, in_b;
    logic [4:0]      in_rd;
    logic            in_signed_div;

    cmdu_pkg::t_mode               r_mode;
    logic [4:0]                    r_rd;
    logic                          r_dbz;
    logic                          r_neg_q, r_neg_r;
    logic [W-1:0]                  r_a, r_b;
    logic [W-1:0]                  r_quo, r_rem, r_dvs;
    logic [cmdu_pkg::CNT_W-1:0]    r_cnt;
    logic [W-1:0]                  r_res_lo, r_res_hi;
    logic [cmdu_pkg::XLEN-1:0]     r_lo, r_hi, r_rd_value;
    logic                          r_rd_write, r_out_dbz;

    logic                          mul_signed, is_mul;
    logic [2*W+1:0]                prod;
    logic [W:0]                    trial, diff;

    assign in_mode       = cmdu_pkg::t_mode'(i_s_tuser);
    assign in_a          = i_s_tdata[W-1:0];
    assign in_b          = i_s_tdata[2*W-1:W];
    assign in_rd         = i_s_tdata[2*W+4:2*W];
    assign in_signed_div = (in_mode == cmdu_pkg::MODE_DIV_S);

    assign o_status.in_is_mul = (in_mode == cmdu_pkg::MODE_MUL_S) ||
                                (in_mode == cmdu_pkg::MODE_MUL_U);
    assign o_status.in_dbz    = (in_b == '0);
    assign o_status.cnt_last  = (r_cnt == '1);

    assign is_mul     = (r_mode == cmdu_pkg::MODE_MUL_S) || (r_mode == cmdu_pkg::MODE_MUL_U);
    assign mul_signed = (r_mode == cmdu_pkg::MODE_MUL_S);
    assign prod = $signed({mul_signed & r_a[W-1], r_a}) * $signed({mul_signed & r_b[W-1], r_b});

    assign trial = {r_rem, r_quo[W-1]};
    assign diff  = trial - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode  <= in_mode;
            r_rd    <= in_rd;
            r_dbz   <= !o_status.in_is_mul && o_status.in_dbz;
            r_a     <= in_a;
            r_b     <= in_b;
            r_neg_q <= in_signed_div && (in_a[W-1] ^ in_b[W-1]);
            r_neg_r <= in_signed_div && in_a[W-1];
            r_quo   <= (in_signed_div && in_a[W-1]) ? -in_a : in_a;
            r_dvs   <= (in_signed_div && in_b[W-1]) ? -in_b : in_b;
            r_rem   <= '0;
            r_cnt   <= '0;
        end else if (i_cmd.div_step) begin
            r_cnt <= r_cnt + 1'b1;
            if (!diff[W]) begin
                r_rem <= diff[W-1:0];
                r_quo <= {r_quo[W-2:0], 1'b1};
            end else begin
                r_rem <= trial[W-1:0];
                r_quo <= {r_quo[W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_res_lo <= prod[W-1:0];
            r_res_hi <= prod[2*W-1:W];
        end else if (i_cmd.fix) begin
            r_res_lo <= r_neg_q ? -r_quo : r_quo;
            r_res_hi <= r_neg_r ? -r_rem : r_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lo <= '0;
            r_hi <= '0;
        end else if (i_cmd.commit && !r_dbz) begin
            r_lo <= cmdu_pkg::sext_word(r_res_lo);
            r_hi <= cmdu_pkg::sext_word(r_res_hi);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_rd_write <= is_mul && (r_rd != '0);
            r_rd_value <= (is_mul && (r_rd != '0)) ? cmdu_pkg::sext_word(r_res_lo) : '0;
            r_out_dbz  <= r_dbz;
        end
    end

    assign o_lo       = r_lo;
    assign o_hi       = r_hi;
    assign o_rd_value = r_rd_value;
    assign o_rd_write = r_rd_write;
    assign o_dbz      = r_out_dbz;

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fix |-> (r_rem < r_dvs))
        else $error("remainder not below divisor");

endmodule
`default_nettype wire

// ===== rtl/cpu_mult_div_unit.sv =====
// Multiply: load at the input transfer, multiply step and commit; the result is then
// valid. Divide: load, 32 radix-2 restoring steps, sign fixup and commit, after which
// the result is valid. Divide by zero: load, then commit. No new item is taken until
// the current one has committed.
// A result not yet taken holds the next item in its commit step until the sink takes it.
// Reset (i_rst_n low, synchronous) clears LO/HI to zero and empties the unit.
`default_nettype none
module cpu_mult_div_unit (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [71:0]  s_axis_tdata,  // rs_value, rt_value, rd_index, zero pad
    input  wire logic [1:0]   s_axis_tuser,  // mode
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [191:0]      m_axis_tdata,  // lo_value, hi_value, rd_value
    output logic [1:0]        m_axis_tuser   // rd_write, divide_by_zero
);

    cmdu_pkg::t_cmd                cmd;
    cmdu_pkg::t_status             status;
    logic [cmdu_pkg::XLEN-1:0]     lo, hi, rd_value;
    logic                          rd_write, dbz;

    cmdu_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .o_m_valid (m_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .i_status  (status),
        .o_cmd     (cmd)
    );

    cmdu_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (s_axis_tdata),
        .i_s_tuser  (s_axis_tuser),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_lo       (lo),
        .o_hi       (hi),
        .o_rd_value (rd_value),
        .o_rd_write (rd_write),
        .o_dbz      (dbz)
    );

    assign m_axis_tdata = {rd_value, hi, lo};
    assign m_axis_tuser = {dbz, rd_write};

endmodule
`default_nettype wire
